// ----- hw/rtl/i2cmrs_pkg.sv -----
// Shared types, codes and constants of the I2C master register sequencer.
package i2cmrs_pkg;

   localparam int BUFFER_DEPTH = 16;
   localparam int IDX_W        = $clog2(BUFFER_DEPTH);
   localparam int CNT_W        = 5;
   localparam int TMO_W        = 16;
   localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd2500;

   // event opcodes
   localparam logic [2:0] OP_LOAD_BYTE   = 3'd0;
   localparam logic [2:0] OP_START_READ  = 3'd1;
   localparam logic [2:0] OP_START_WRITE = 3'd2;
   localparam logic [2:0] OP_TX_READY    = 3'd3;
   localparam logic [2:0] OP_RX_BYTE     = 3'd4;
   localparam logic [2:0] OP_NACK        = 3'd5;
   localparam logic [2:0] OP_MS_TICK     = 3'd6;

   // sequencer modes
   localparam logic [2:0] MODE_IDLE      = 3'd0;
   localparam logic [2:0] MODE_SEND_REG  = 3'd1;
   localparam logic [2:0] MODE_SWITCH_RX = 3'd2;
   localparam logic [2:0] MODE_RX_DATA   = 3'd3;
   localparam logic [2:0] MODE_TX_DATA   = 3'd4;
   localparam logic [2:0] MODE_NACK      = 3'd5;
   localparam logic [2:0] MODE_TIMEOUT   = 3'd6;

   typedef struct packed {
      logic [2:0]       opcode;
      logic [6:0]       chip_addr;
      logic [7:0]       reg_offset;
      logic [CNT_W-1:0] count;
      logic [7:0]       data_byte;
      logic [3:0]       buffer_slot;
   } item_type;

   typedef struct packed {
      logic [2:0]       mode;
      logic [6:0]       target;
      logic [7:0]       reg_byte;
      logic [CNT_W-1:0] rx_rem;
      logic [CNT_W-1:0] tx_rem;
      logic [3:0]       rx_pos;
      logic [3:0]       tx_pos;
      logic             stop_seen;
      logic [TMO_W-1:0] elapsed;
      logic             write_active;
   } state_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       drive_byte_valid;
      logic [7:0] drive_byte;
      logic       send_start;
      logic       transmit_dir;
      logic       send_stop;
      logic [6:0] target_addr;
      logic       got_byte_valid;
      logic [7:0] got_byte;
      logic [3:0] got_index;
      logic       transfer_done;
   } result_type;

endpackage

// ----- hw/rtl/i2c_master_register_sequencer.sv -----
// Top level of the I2C master register sequencer.
// One controller event is taken per clock cycle while req_stall is low, and gives exactly
// one result transaction, which appears on the rsp_ side in the cycle after the event is
// accepted. The sequencer state and the 16-byte transmit buffer update at that same edge,
// so a following event sees them at once; a single result register sits between the two
// sides, so a new event enters in the same cycle the held result is taken, and req_stall
// rises only while a held result is stalled by rsp_stall.
// Buffer entries hold no value until loaded; there is no clearing pass after reset.
// The write timeout limit is written through csr_wr_en/csr_wr_data; the user must write
// it only while idle, as the block does not enforce this. It resets to 2500 ticks.
module i2c_master_register_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [6:0]  req_chip_addr,
   input  logic [7:0]  req_reg_offset,
   input  logic [4:0]  req_count,
   input  logic [7:0]  req_data_byte,
   input  logic [3:0]  req_buffer_slot,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_mode,
   output logic        rsp_drive_byte_valid,
   output logic [7:0]  rsp_drive_byte,
   output logic        rsp_send_start,
   output logic        rsp_transmit_dir,
   output logic        rsp_send_stop,
   output logic [6:0]  rsp_target_addr,
   output logic        rsp_got_byte_valid,
   output logic [7:0]  rsp_got_byte,
   output logic [3:0]  rsp_got_index,
   output logic        rsp_transfer_done
);
   import i2cmrs_pkg::*;

   state_type        state_ff, state_in;
   result_type       rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [TMO_W-1:0] timeout_ff;
   logic [7:0]       tx_store_ff [BUFFER_DEPTH];
   item_type         item;
   logic             store_we;
   logic             req_take;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   assign item.opcode      = req_opcode;
   assign item.chip_addr   = req_chip_addr;
   assign item.reg_offset  = req_reg_offset;
   assign item.count       = req_count;
   assign item.data_byte   = req_data_byte;
   assign item.buffer_slot = req_buffer_slot;

   i2cmrs_step u_step (
      .item       (item),
      .cur        (state_ff),
      .store_byte (tx_store_ff[state_ff.tx_pos[IDX_W-1:0]]),
      .timeout_ms (timeout_ff),
      .nxt        (state_in),
      .res        (rsp_in),
      .store_we   (store_we)
   );

   // hold a stalled result, otherwise refill or drop
   assign rsp_valid_in = req_take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= rsp_in;
      end
      if (req_take && store_we) begin
         tx_store_ff[req_buffer_slot[IDX_W-1:0]] <= req_data_byte;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_mode             = rsp_ff.mode;
   assign rsp_drive_byte_valid = rsp_ff.drive_byte_valid;
   assign rsp_drive_byte       = rsp_ff.drive_byte;
   assign rsp_send_start       = rsp_ff.send_start;
   assign rsp_transmit_dir     = rsp_ff.transmit_dir;
   assign rsp_send_stop        = rsp_ff.send_stop;
   assign rsp_target_addr      = rsp_ff.target_addr;
   assign rsp_got_byte_valid   = rsp_ff.got_byte_valid;
   assign rsp_got_byte         = rsp_ff.got_byte;
   assign rsp_got_index        = rsp_ff.got_index;
   assign rsp_transfer_done    = rsp_ff.transfer_done;

endmodule

// ----- hw/rtl/i2cmrs_step.sv -----
// Next-state and result logic for one controller event.
module i2cmrs_step (
   input  i2cmrs_pkg::item_type     item,
   input  i2cmrs_pkg::state_type    cur,
   input  logic [7:0]               store_byte,
   input  logic [15:0]              timeout_ms,
   output i2cmrs_pkg::state_type    nxt,
   output i2cmrs_pkg::result_type   res,
   output logic                     store_we
);
   import i2cmrs_pkg::*;

   logic [CNT_W-1:0] count_clamped;
   logic [CNT_W-1:0] rx_rem_dec;

   assign count_clamped = (32'(item.count) > BUFFER_DEPTH) ? CNT_W'(BUFFER_DEPTH) : item.count;
   assign rx_rem_dec    = cur.rx_rem - CNT_W'(1);

   always_comb begin
      nxt      = cur;
      res      = '0;
      store_we = 1'b0;
      case (item.opcode)
         OP_LOAD_BYTE: begin
            store_we = 32'(item.buffer_slot) < BUFFER_DEPTH;
         end
         OP_START_READ: begin
            nxt.mode         = MODE_SEND_REG;
            nxt.target       = item.chip_addr;
            nxt.reg_byte     = item.reg_offset;
            nxt.rx_pos       = '0;
            nxt.tx_pos       = '0;
            nxt.rx_rem       = count_clamped;
            nxt.tx_rem       = '0;
            nxt.write_active = 1'b0;
            res.send_start   = 1'b1;
            res.transmit_dir = 1'b1;
         end
         OP_START_WRITE: begin
            nxt.mode         = MODE_SEND_REG;
            nxt.target       = item.chip_addr;
            nxt.reg_byte     = item.reg_offset;
            nxt.rx_pos       = '0;
            nxt.tx_pos       = '0;
            nxt.tx_rem       = count_clamped;
            nxt.rx_rem       = '0;
            nxt.stop_seen    = 1'b0;
            nxt.elapsed      = '0;
            nxt.write_active = 1'b1;
            res.send_start   = 1'b1;
            res.transmit_dir = 1'b1;
         end
         OP_TX_READY: begin
            if (cur.mode == MODE_SEND_REG) begin
               res.drive_byte_valid = 1'b1;
               res.drive_byte       = cur.reg_byte;
               nxt.mode = (cur.rx_rem != '0) ? MODE_SWITCH_RX : MODE_TX_DATA;
            end else if (cur.mode == MODE_SWITCH_RX) begin
               // repeated start in receive mode; stop early for a single byte
               nxt.mode       = MODE_RX_DATA;
               res.send_start = 1'b1;
               res.send_stop  = (cur.rx_rem == CNT_W'(1));
            end else if (cur.mode == MODE_TX_DATA) begin
               if (cur.tx_rem != '0) begin
                  res.drive_byte_valid = 1'b1;
                  res.drive_byte       = (32'(cur.tx_pos) < BUFFER_DEPTH) ? store_byte : 8'd0;
                  nxt.tx_pos           = cur.tx_pos + 4'd1;
                  nxt.tx_rem           = cur.tx_rem - CNT_W'(1);
               end else begin
                  res.send_stop     = 1'b1;
                  res.transfer_done = 1'b1;
                  nxt.stop_seen     = 1'b1;
                  nxt.mode          = MODE_IDLE;
                  nxt.write_active  = 1'b0;
               end
            end
         end
         OP_RX_BYTE: begin
            if (cur.mode == MODE_RX_DATA) begin
               if (cur.rx_rem != '0) begin
                  res.got_byte_valid = 1'b1;
                  res.got_byte       = item.data_byte;
                  res.got_index      = cur.rx_pos;
                  nxt.rx_pos         = cur.rx_pos + 4'd1;
                  nxt.rx_rem         = rx_rem_dec;
               end
               if (nxt.rx_rem == CNT_W'(1)) begin
                  res.send_stop = 1'b1;
               end else if (nxt.rx_rem == '0) begin
                  nxt.mode          = MODE_IDLE;
                  res.transfer_done = 1'b1;
               end
            end
         end
         OP_NACK: begin
            nxt.mode = MODE_NACK;
         end
         OP_MS_TICK: begin
            if (cur.write_active && !cur.stop_seen) begin
               // saturate the tick count
               if (cur.elapsed != '1) begin
                  nxt.elapsed = cur.elapsed + TMO_W'(1);
               end
               if (nxt.elapsed > timeout_ms) begin
                  nxt.mode          = MODE_TIMEOUT;
                  nxt.write_active  = 1'b0;
                  res.transfer_done = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      res.mode        = nxt.mode;
      res.target_addr = nxt.target;
   end

endmodule

// ----- hw/rtl/i2cmrs_checker.sv -----
// Port-level checker for the I2C master register sequencer, with its bind.
module i2cmrs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [2:0]  req_opcode,
   input logic [6:0]  req_chip_addr,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_mode,
   input logic        rsp_drive_byte_valid,
   input logic [7:0]  rsp_drive_byte,
   input logic        rsp_send_start,
   input logic        rsp_transmit_dir,
   input logic [6:0]  rsp_target_addr,
   input logic        rsp_got_byte_valid,
   input logic [7:0]  rsp_got_byte,
   input logic [3:0]  rsp_got_index
);
   import i2cmrs_pkg::*;

   // a stalled result transaction keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mode) && $stable(rsp_target_addr)
         && $stable(rsp_drive_byte))
      else $error("stalled result changed");

   // a start event answers next cycle with a transmit start to the new device
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_opcode == OP_START_READ || req_opcode == OP_START_WRITE)
      |=> rsp_valid && rsp_send_start && rsp_transmit_dir && rsp_mode == MODE_SEND_REG
         && rsp_target_addr == $past(req_chip_addr))
      else $error("start event gave wrong result");

   a_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_send_start |-> !rsp_transmit_dir)
      else $error("direction without start");

   a_got_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_got_byte_valid |-> rsp_got_byte == 8'd0 && rsp_got_index == 4'd0)
      else $error("received byte fields set without valid");

   a_drive_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_drive_byte_valid |-> rsp_drive_byte == 8'd0)
      else $error("drive byte set without valid");

endmodule

bind i2c_master_register_sequencer i2cmrs_checker u_i2cmrs_checker (.*);

// ----- tb/i2cmrs_seq_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the I2C master register sequencer: mirrors its state and checks every result.
module i2cmrs_seq_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [6:0]  req_chip_addr,
   input  logic [7:0]  req_reg_offset,
   input  logic [4:0]  req_count,
   input  logic [7:0]  req_data_byte,
   input  logic [3:0]  req_buffer_slot,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_mode,
   input  logic        rsp_drive_byte_valid,
   input  logic [7:0]  rsp_drive_byte,
   input  logic        rsp_send_start,
   input  logic        rsp_transmit_dir,
   input  logic        rsp_send_stop,
   input  logic [6:0]  rsp_target_addr,
   input  logic        rsp_got_byte_valid,
   input  logic [7:0]  rsp_got_byte,
   input  logic [3:0]  rsp_got_index,
   input  logic        rsp_transfer_done,
   output int          mismatch_count,
   output int          actions_pending
);
   import i2cmrs_pkg::*;

   result_type  expected_actions[$];
   int          mismatches = 0;

   logic [15:0] timeout_limit;
   logic [2:0]  seq_mode;
   logic [6:0]  target;
   logic [7:0]  reg_byte;
   int          rx_left, tx_left, rx_pos, tx_pos;
   logic        stop_seen, write_busy;
   logic [15:0] elapsed;
   logic [7:0]  tx_image [BUFFER_DEPTH];

   assign mismatch_count = mismatches;

   task automatic report_mismatch(input string what);
      if (mismatches < 100)
         $display("%0t checker: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   // Advance the mirrored sequencer by one event and return the bus action it produces.
   function automatic result_type next_bus_action(input item_type ev);
      result_type r;
      int         n;
      r = '0;
      n = (int'(ev.count) > BUFFER_DEPTH) ? BUFFER_DEPTH : int'(ev.count);
      case (ev.opcode)
         OP_LOAD_BYTE: begin
            if (int'(ev.buffer_slot) < BUFFER_DEPTH)
               tx_image[ev.buffer_slot] = ev.data_byte;
         end
         OP_START_READ, OP_START_WRITE: begin
            seq_mode = MODE_SEND_REG;
            target   = ev.chip_addr;
            reg_byte = ev.reg_offset;
            rx_pos   = 0;
            tx_pos   = 0;
            r.send_start   = 1'b1;
            r.transmit_dir = 1'b1;
            if (ev.opcode == OP_START_READ) begin
               rx_left    = n;
               tx_left    = 0;
               write_busy = 1'b0;
            end else begin
               tx_left    = n;
               rx_left    = 0;
               stop_seen  = 1'b0;
               elapsed    = '0;
               write_busy = 1'b1;
            end
         end
         OP_TX_READY: begin
            if (seq_mode == MODE_SEND_REG) begin
               r.drive_byte_valid = 1'b1;
               r.drive_byte       = reg_byte;
               seq_mode = (rx_left != 0) ? MODE_SWITCH_RX : MODE_TX_DATA;
            end else if (seq_mode == MODE_SWITCH_RX) begin
               seq_mode       = MODE_RX_DATA;
               r.send_start   = 1'b1;
               r.transmit_dir = 1'b0;
               r.send_stop    = (rx_left == 1);
            end else if (seq_mode == MODE_TX_DATA) begin
               if (tx_left != 0) begin
                  r.drive_byte_valid = 1'b1;
                  r.drive_byte       = (tx_pos < BUFFER_DEPTH) ? tx_image[tx_pos] : 8'h00;
                  tx_pos++;
                  tx_left--;
               end else begin
                  r.send_stop     = 1'b1;
                  r.transfer_done = 1'b1;
                  stop_seen       = 1'b1;
                  write_busy      = 1'b0;
                  seq_mode        = MODE_IDLE;
               end
            end
         end
         OP_RX_BYTE: begin
            if (seq_mode == MODE_RX_DATA) begin
               if (rx_left != 0) begin
                  r.got_byte_valid = 1'b1;
                  r.got_byte       = ev.data_byte;
                  r.got_index      = 4'(rx_pos);
                  rx_pos++;
                  rx_left--;
               end
               if (rx_left == 1) begin
                  r.send_stop = 1'b1;
               end else if (rx_left == 0) begin
                  seq_mode        = MODE_IDLE;
                  r.transfer_done = 1'b1;
               end
            end
         end
         OP_NACK: begin
            seq_mode = MODE_NACK;
         end
         OP_MS_TICK: begin
            // only an open write without stop counts ticks
            if (write_busy && !stop_seen) begin
               if (elapsed != 16'hFFFF)
                  elapsed++;
               if (elapsed > timeout_limit) begin
                  seq_mode        = MODE_TIMEOUT;
                  write_busy      = 1'b0;
                  r.transfer_done = 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.mode        = seq_mode;
      r.target_addr = target;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      result_type seen, want;
      item_type   ev;
      if (reset) begin
         timeout_limit = TIMEOUT_RESET;
         seq_mode      = MODE_IDLE;
         target        = '0;
         reg_byte      = '0;
         rx_left       = 0;
         tx_left       = 0;
         rx_pos        = 0;
         tx_pos        = 0;
         stop_seen     = 1'b0;
         write_busy    = 1'b0;
         elapsed       = '0;
         expected_actions.delete();
      end else begin
         if (csr_wr_en)
            timeout_limit = csr_wr_data;
         // compare before predicting: a result always belongs to an earlier event
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_mode, rsp_drive_byte_valid, rsp_drive_byte, rsp_send_start,
                    rsp_transmit_dir, rsp_send_stop, rsp_target_addr, rsp_got_byte_valid,
                    rsp_got_byte, rsp_got_index, rsp_transfer_done};
            if (expected_actions.size() == 0) begin
               report_mismatch("result transaction with nothing expected");
            end else begin
               want = expected_actions.pop_front();
               check_field("mode", seen.mode, want.mode);
               check_field("drive_byte_valid", seen.drive_byte_valid, want.drive_byte_valid);
               check_field("drive_byte", seen.drive_byte, want.drive_byte);
               check_field("send_start", seen.send_start, want.send_start);
               check_field("transmit_dir", seen.transmit_dir, want.transmit_dir);
               check_field("send_stop", seen.send_stop, want.send_stop);
               check_field("target_addr", seen.target_addr, want.target_addr);
               check_field("got_byte_valid", seen.got_byte_valid, want.got_byte_valid);
               check_field("got_byte", seen.got_byte, want.got_byte);
               check_field("got_index", seen.got_index, want.got_index);
               check_field("transfer_done", seen.transfer_done, want.transfer_done);
            end
         end
         if (req_valid && !req_stall) begin
            ev = {req_opcode, req_chip_addr, req_reg_offset, req_count, req_data_byte,
                  req_buffer_slot};
            expected_actions.push_back(next_bus_action(ev));
         end
      end
      actions_pending <= expected_actions.size();
   end

endmodule

// ----- tb/tb_i2c_master_register_sequencer.sv -----
`timescale 1ns / 1ps
// Testbench top for the I2C master register sequencer: clock, reset, event stimulus, verdict.
module tb_i2c_master_register_sequencer;
   import i2cmrs_pkg::*;

   localparam logic [2:0] OP_UNUSED    = 3'd7;
   localparam int         LIMIT_CYCLES = 400_000;
   localparam int         HOLD_CYCLES  = 200;
   localparam int         PHASE_ITEMS  = 245;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_opcode = '0;
   logic [6:0]  req_chip_addr = '0;
   logic [7:0]  req_reg_offset = '0;
   logic [4:0]  req_count = '0;
   logic [7:0]  req_data_byte = '0;
   logic [3:0]  req_buffer_slot = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_mode;
   logic        rsp_drive_byte_valid;
   logic [7:0]  rsp_drive_byte;
   logic        rsp_send_start;
   logic        rsp_transmit_dir;
   logic        rsp_send_stop;
   logic [6:0]  rsp_target_addr;
   logic        rsp_got_byte_valid;
   logic [7:0]  rsp_got_byte;
   logic [3:0]  rsp_got_index;
   logic        rsp_transfer_done;
   int          mismatch_count;
   int          actions_pending;

   int                    cycle_count = 0;
   int                    items_sent = 0;
   int                    gap_pct = 0;
   int                    stall_pct = 0;
   bit                    pressure_on = 1'b0;
   logic [15:0]           timeout_now = TIMEOUT_RESET;
   bit [BUFFER_DEPTH-1:0] loaded = '0;

   i2c_master_register_sequencer DUT (.*);

   i2cmrs_seq_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb_i2c_master_register_sequencer: FAIL");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off to back the block up
   initial begin : result_side
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (pressure_on && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   task automatic send_item(input item_type it);
      req_valid       <= 1'b1;
      req_opcode      <= it.opcode;
      req_chip_addr   <= it.chip_addr;
      req_reg_offset  <= it.reg_offset;
      req_count       <= it.count;
      req_data_byte   <= it.data_byte;
      req_buffer_slot <= it.buffer_slot;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (it.opcode == OP_LOAD_BYTE)
         loaded[it.buffer_slot] = 1'b1;
      // idle in repeated random draws so the idle share matches gap_pct
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_event(input logic [2:0] op, input logic [6:0] dev,
                             input logic [7:0] reg_a, input logic [4:0] cnt,
                             input logic [7:0] dat, input logic [3:0] slot);
      send_item({op, dev, reg_a, cnt, dat, slot});
   endtask

   function automatic item_type random_item(input logic [2:0] op);
      item_type it;
      it.opcode      = op;
      it.chip_addr   = 7'($urandom);
      it.reg_offset  = 8'($urandom);
      it.count       = 5'($urandom_range(0, 31));
      it.data_byte   = 8'($urandom);
      it.buffer_slot = 4'($urandom_range(0, 15));
      return it;
   endfunction

   // Pick a write length that only sends buffer entries already loaded.
   function automatic logic [4:0] write_count();
      int run;
      run = 0;
      while (run < BUFFER_DEPTH && loaded[run])
         run++;
      if (run < BUFFER_DEPTH)
         return 5'($urandom_range(0, run));
      if ($urandom_range(4) == 0)
         return 5'($urandom_range(BUFFER_DEPTH + 1, 31));
      return 5'($urandom_range(0, BUFFER_DEPTH));
   endfunction

   task automatic send_ticks();
      int span;
      span = (timeout_now < 60) ? $urandom_range(1, timeout_now + 2) : $urandom_range(1, 6);
      repeat (span) send_item(random_item(OP_MS_TICK));
   endtask

   task automatic write_sequence();
      item_type it;
      int       n, k;
      repeat ($urandom_range(0, 4)) send_item(random_item(OP_LOAD_BYTE));
      it = random_item(OP_START_WRITE);
      it.count = write_count();
      send_item(it);
      n = (it.count > BUFFER_DEPTH) ? BUFFER_DEPTH : it.count;
      // register byte, data bytes, then the stop
      for (k = 0; k < n + 2; k++) begin
         if ($urandom_range(9) == 0)
            send_ticks();
         if ($urandom_range(39) == 0) begin
            send_item(random_item(OP_NACK));
            send_ticks();
            break;
         end
         send_item(random_item(OP_TX_READY));
      end
   endtask

   task automatic read_sequence();
      item_type it;
      int       n, k;
      it = random_item(OP_START_READ);
      it.count = ($urandom_range(9) == 0) ? 5'($urandom_range(17, 31))
                                          : 5'($urandom_range(0, 16));
      send_item(it);
      n = (it.count > BUFFER_DEPTH) ? BUFFER_DEPTH : it.count;
      send_item(random_item(OP_TX_READY));
      if (n > 0)
         send_item(random_item(OP_TX_READY));
      for (k = 0; k < n; k++) begin
         if ($urandom_range(29) == 0) begin
            send_item(random_item(OP_NACK));
            break;
         end
         send_item(random_item(OP_RX_BYTE));
      end
      if ($urandom_range(4) == 0)
         send_item(random_item($urandom_range(0, 1) ? OP_RX_BYTE : OP_TX_READY));
   endtask

   task automatic noise_burst();
      item_type it;
      repeat ($urandom_range(1, 6)) begin
         it = random_item(3'($urandom_range(0, 7)));
         if (it.opcode == OP_START_WRITE)
            it.count = write_count();
         send_item(it);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (actions_pending != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_timeout(input logic [15:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      timeout_now  = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_phase(input logic [15:0] value, input int tx_pct, input int rx_pct,
                            input bit hold, input int n);
      int first, pick;
      set_timeout(value);
      gap_pct     = tx_pct;
      stall_pct   = rx_pct;
      pressure_on = hold;
      first       = items_sent;
      while (items_sent - first < n) begin
         pick = $urandom_range(99);
         if (pick < 38)
            write_sequence();
         else if (pick < 76)
            read_sequence();
         else if (pick < 86)
            send_ticks();
         else
            noise_burst();
      end
   endtask

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_timeout(16'd1);
      send_event(OP_LOAD_BYTE, 7'h00, 8'h00, 5'd0, 8'hFF, 4'd0);
      send_event(OP_LOAD_BYTE, 7'h00, 8'h00, 5'd0, 8'h00, 4'd1);
      send_event(OP_LOAD_BYTE, 7'h7F, 8'hFF, 5'd31, 8'hA5, 4'd15);
      // full write of two bytes
      send_event(OP_START_WRITE, 7'h7F, 8'hFF, 5'd2, 8'h00, 4'd0);
      repeat (4) send_event(OP_TX_READY, 7'h00, 8'h00, 5'd0, 8'h00, 4'd0);
      // single byte read: stop goes with the repeated start
      send_event(OP_START_READ, 7'h00, 8'h00, 5'd1, 8'h00, 4'd0);
      repeat (2) send_event(OP_TX_READY, 7'h00, 8'h00, 5'd0, 8'h00, 4'd0);
      send_event(OP_RX_BYTE, 7'h00, 8'h00, 5'd0, 8'hFF, 4'd0);
      // read of nothing ends like an empty write
      send_event(OP_START_READ, 7'h2A, 8'h5A, 5'd0, 8'h00, 4'd0);
      repeat (2) send_event(OP_TX_READY, 7'h00, 8'h00, 5'd0, 8'h00, 4'd0);
      // ignored events while idle, and the unused opcode
      send_event(OP_RX_BYTE, 7'h00, 8'h00, 5'd0, 8'h00, 4'd0);
      send_event(OP_TX_READY, 7'h00, 8'h00, 5'd0, 8'h00, 4'd0);
      send_event(OP_UNUSED, 7'h7F, 8'hFF, 5'd31, 8'hFF, 4'd15);
      // oversized count, then NACK
      send_event(OP_START_READ, 7'h55, 8'hC3, 5'd31, 8'h00, 4'd0);
      send_event(OP_NACK, 7'h00, 8'h00, 5'd0, 8'h00, 4'd0);
      send_event(OP_TX_READY, 7'h00, 8'h00, 5'd0, 8'h00, 4'd0);
      // write left pending across a NACK runs into the timeout
      send_event(OP_START_WRITE, 7'h01, 8'h10, 5'd0, 8'h00, 4'd0);
      send_event(OP_NACK, 7'h00, 8'h00, 5'd0, 8'h00, 4'd0);
      repeat (3) send_event(OP_MS_TICK, 7'h00, 8'h00, 5'd0, 8'h00, 4'd0);

      run_phase(16'd1, 0, 0, 1'b1, PHASE_ITEMS);
      run_phase(16'hFFFF, 78, 0, 1'b0, PHASE_ITEMS);
      run_phase(16'($urandom_range(2, 40)), 0, 78, 1'b0, PHASE_ITEMS);
      run_phase(16'd3, 24, 24, 1'b0, PHASE_ITEMS);
      run_phase(TIMEOUT_RESET, 24, 24, 1'b0, PHASE_ITEMS);
      drain();

      if (mismatch_count == 0)
         $display("tb_i2c_master_register_sequencer: PASS");
      else
         $display("tb_i2c_master_register_sequencer: FAIL");
      $finish;
   end

endmodule
